>>> rtl/fvmcc_pkg.sv
// Shared types, codes and fixed-point helpers for the face convection block.
package fvmcc_pkg;

    // Boundary condition codes
    localparam logic [2:0] BC_NONE      = 3'd0;
    localparam logic [2:0] BC_DIRICHLET = 3'd1;
    localparam logic [2:0] BC_NEUMANN   = 3'd2;
    localparam logic [2:0] BC_MIXED     = 3'd3;
    localparam logic [2:0] BC_EMPTY     = 3'd4;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_SCHEME = 2'd0;
    localparam logic [1:0] REG_VEL_X  = 2'd1;
    localparam logic [1:0] REG_VEL_Y  = 2'd2;
    localparam logic [1:0] REG_VEL_Z  = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Operation chosen by the front end for one face
    typedef enum logic [2:0] {
        OP_CENTRAL,
        OP_UPWIND,
        OP_DIRICHLET,
        OP_NEUMANN,
        OP_NOTHING
    } face_op_t;

    // Classified face word passed from front to back
    typedef struct packed {
        face_op_t           op;
        logic [15:0]        owner;
        logic [15:0]        neighbour;
        logic               bnd;
        logic signed [31:0] flux;
        logic [16:0]        fx;
        logic [30:0]        delta;
        logic signed [31:0] bval;
    } face_word_t;

    // Queue status travelling between the queue and the top level
    typedef struct packed {
        logic empty;
        logic almost_full;
    } queue_status_t;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        if (x > 68'sh0_7FFF_FFFF)
            sat32 = 32'sh7FFF_FFFF;
        else if (x < -68'sh0_8000_0000)
            sat32 = 32'sh8000_0000;
        else
            sat32 = x[31:0];
    endfunction

endpackage

>>> rtl/fvmcc_front.sv
// Front end: flux pipeline and face classification.
module fvmcc_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      scheme,
    input  logic signed [31:0]        vel_x,
    input  logic signed [31:0]        vel_y,
    input  logic signed [31:0]        vel_z,
    input  logic [15:0]               owner_index,
    input  logic [15:0]               neighbour_index,
    input  logic                      is_boundary,
    input  logic signed [31:0]        normal_x,
    input  logic signed [31:0]        normal_y,
    input  logic signed [31:0]        normal_z,
    input  logic [30:0]               face_area,
    input  logic [16:0]               interp_factor,
    input  logic [30:0]               face_delta,
    input  logic [2:0]                bc_type,
    input  logic signed [31:0]        boundary_value,
    output logic                      out_valid,
    output fvmcc_pkg::face_word_t     out_word
);

    // stage 1: n * area, stage 2: s * u, stage 3: sum and classify
    logic               v1_reg, v2_reg, v3_reg;
    logic signed [63:0] sa_reg [3];
    logic signed [63:0] su_reg [3];
    logic [15:0]        own1_reg, own2_reg, nb1_reg, nb2_reg;
    logic               bnd1_reg, bnd2_reg, sch1_reg, sch2_reg;
    logic [16:0]        fx1_reg, fx2_reg;
    logic [30:0]        dl1_reg, dl2_reg;
    logic [2:0]         bc1_reg, bc2_reg;
    logic signed [31:0] bv1_reg, bv2_reg;
    logic signed [31:0] s_vec [3];
    logic signed [31:0] flux;
    logic signed [67:0] fsum;
    fvmcc_pkg::face_word_t word_next, word_reg;
    fvmcc_pkg::face_op_t   op;

    // saturated, floored scaled normal and saturated flux sum
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s_vec[i] = fvmcc_pkg::sat32(68'(sa_reg[i] >>> FRAC_BITS));
        fsum = 68'(su_reg[0] >>> FRAC_BITS) + 68'(su_reg[1] >>> FRAC_BITS)
             + 68'(su_reg[2] >>> FRAC_BITS);
        flux = fvmcc_pkg::sat32(fsum);
    end

    // classify the face
    always_comb
    begin
        if (!bnd2_reg)
            op = sch2_reg ? fvmcc_pkg::OP_UPWIND : fvmcc_pkg::OP_CENTRAL;
        else if (bc2_reg == fvmcc_pkg::BC_DIRICHLET)
            op = fvmcc_pkg::OP_DIRICHLET;
        else if (bc2_reg == fvmcc_pkg::BC_NEUMANN)
            op = fvmcc_pkg::OP_NEUMANN;
        else
            op = fvmcc_pkg::OP_NOTHING;
        word_next.op        = op;
        word_next.owner     = own2_reg;
        word_next.neighbour = nb2_reg;
        word_next.bnd       = bnd2_reg;
        word_next.flux      = flux;
        word_next.fx        = fx2_reg;
        word_next.delta     = dl2_reg;
        word_next.bval      = bv2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        sa_reg[0] <= normal_x * $signed({1'b0, face_area});
        sa_reg[1] <= normal_y * $signed({1'b0, face_area});
        sa_reg[2] <= normal_z * $signed({1'b0, face_area});
        own1_reg  <= owner_index;
        nb1_reg   <= neighbour_index;
        bnd1_reg  <= is_boundary;
        sch1_reg  <= scheme;
        fx1_reg   <= interp_factor;
        dl1_reg   <= face_delta;
        bc1_reg   <= bc_type;
        bv1_reg   <= boundary_value;
        su_reg[0] <= s_vec[0] * vel_x;
        su_reg[1] <= s_vec[1] * vel_y;
        su_reg[2] <= s_vec[2] * vel_z;
        own2_reg  <= own1_reg;
        nb2_reg   <= nb1_reg;
        bnd2_reg  <= bnd1_reg;
        sch2_reg  <= sch1_reg;
        fx2_reg   <= fx1_reg;
        dl2_reg   <= dl1_reg;
        bc2_reg   <= bc1_reg;
        bv2_reg   <= bv1_reg;
        word_reg  <= word_next;
    end

    assign out_valid = v3_reg;
    assign out_word  = word_reg;

endmodule

>>> rtl/fvmcc_queue.sv
// Short queue between the front and back ends.
module fvmcc_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  fvmcc_pkg::face_word_t      push_word,
    input  logic                       pop,
    output fvmcc_pkg::face_word_t      head_word,
    output fvmcc_pkg::queue_status_t   status
);

    fvmcc_pkg::face_word_t          mem [fvmcc_pkg::QUEUE_DEPTH];
    logic [fvmcc_pkg::QUEUE_AW-1:0] wp_reg, rp_reg;
    logic [fvmcc_pkg::QUEUE_AW:0]   cnt_reg;
    logic                           do_pop;

    assign do_pop    = pop && (cnt_reg != '0);
    assign head_word = mem[rp_reg];
    assign status.empty       = (cnt_reg == '0);
    assign status.almost_full = (cnt_reg >= (fvmcc_pkg::QUEUE_AW+1)'(fvmcc_pkg::QUEUE_DEPTH - 1));

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (do_pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (fvmcc_pkg::QUEUE_AW+1)'(push)
                     - (fvmcc_pkg::QUEUE_AW+1)'(do_pop);
        end
    end

endmodule

>>> rtl/fvmcc_back.sv
// Back end: coefficient and source computation for one classified face.
module fvmcc_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  fvmcc_pkg::face_word_t  in_word,
    output logic                   done,
    output logic signed [31:0]     face_flux,
    output logic signed [31:0]     coef_pp,
    output logic signed [31:0]     coef_pn,
    output logic signed [31:0]     coef_np,
    output logic signed [31:0]     coef_nn,
    output logic signed [31:0]     source_add,
    output logic [15:0]            owner_out,
    output logic [15:0]            neighbour_out,
    output logic                   boundary_out
);

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    // stage 1: first products
    logic               v1_reg, v2_reg, v3_reg;
    fvmcc_pkg::face_word_t w1_reg, w2_reg;
    logic signed [63:0] pa_reg, pb_reg;
    logic signed [32:0] negf;
    logic signed [31:0] a_op, t_op;
    logic signed [31:0] a_sat, b_sat, t_sat;
    logic signed [63:0] src_prod_reg;
    logic signed [31:0] pp2_reg, pn2_reg;
    logic signed [31:0] pp, pn, src;

    // exact negation, one bit wider so the most negative flux stays exact
    assign negf = -33'(in_word.flux);
    always_comb
    begin
        case (in_word.op)
            fvmcc_pkg::OP_DIRICHLET: a_op = in_word.bval;
            fvmcc_pkg::OP_NEUMANN:   a_op = $signed({1'b0, in_word.delta});
            default:                 a_op = 32'(signed'({1'b0, in_word.fx}));
        endcase
    end

    always_ff @(posedge clk)
    begin
        w1_reg <= in_word;
        if (in_word.op == fvmcc_pkg::OP_CENTRAL)
            pa_reg <= 64'(a_op) * 64'(in_word.flux);
        else
            pa_reg <= 64'(a_op) * 64'(negf);
        pb_reg <= 64'(ONE - $signed({15'b0, in_word.fx})) * 64'(in_word.flux);
    end

    // stage 2: saturate, second product for Neumann
    assign a_sat = fvmcc_pkg::sat32(68'(pa_reg >>> FRAC_BITS));
    assign b_sat = fvmcc_pkg::sat32(68'(pb_reg >>> FRAC_BITS));
    assign t_op  = (w1_reg.op == fvmcc_pkg::OP_NEUMANN) ? a_sat : 32'sd0;

    always_comb
    begin
        pp = '0;
        pn = '0;
        case (w1_reg.op)
            fvmcc_pkg::OP_CENTRAL:
            begin
                pp = a_sat;
                pn = b_sat;
            end
            fvmcc_pkg::OP_UPWIND:
            begin
                if (w1_reg.flux >= 0)
                    pp = w1_reg.flux;
                else
                    pn = w1_reg.flux;
            end
            fvmcc_pkg::OP_NEUMANN: pp = w1_reg.flux;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        w2_reg       <= w1_reg;
        pp2_reg      <= pp;
        pn2_reg      <= pn;
        if (w1_reg.op == fvmcc_pkg::OP_DIRICHLET)
            src_prod_reg <= 64'(a_sat) <<< FRAC_BITS;
        else
            src_prod_reg <= 64'(t_op) * 64'(w1_reg.bval);
    end

    // stage 3: output register
    assign t_sat = fvmcc_pkg::sat32(68'(src_prod_reg >>> FRAC_BITS));
    always_comb
    begin
        case (w2_reg.op)
            fvmcc_pkg::OP_DIRICHLET, fvmcc_pkg::OP_NEUMANN: src = t_sat;
            default: src = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // boundary faces carry owner entries only
    always_ff @(posedge clk)
    begin
        face_flux     <= w2_reg.flux;
        coef_pp       <= pp2_reg;
        coef_pn       <= pn2_reg;
        coef_np       <= w2_reg.bnd ? 32'sd0 : fvmcc_pkg::sat32(-68'(pp2_reg));
        coef_nn       <= fvmcc_pkg::sat32(-68'(pn2_reg));
        source_add    <= src;
        owner_out     <= w2_reg.owner;
        neighbour_out <= w2_reg.neighbour;
        boundary_out  <= w2_reg.bnd;
    end

    assign done = v3_reg;

endmodule

>>> rtl/fvm_face_convection_coefficients.sv
// Top level of the face convection coefficient block.
// One face is taken per cycle while busy is low; each face gives exactly one result
// strobed on done, after passing through three flux stages in the front end, the
// queue, and three coefficient stages in the back end. The receiver cannot
// stall, so busy stays low in normal streaming; the queue between the ends only
// fills if the back end were held. The user must write registers through the APB
// port only while no face is in flight; the block itself does not enforce this.
module fvm_face_convection_coefficients #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        owner_index,
    input  logic [15:0]        neighbour_index,
    input  logic               is_boundary,
    input  logic signed [31:0] normal_x,
    input  logic signed [31:0] normal_y,
    input  logic signed [31:0] normal_z,
    input  logic [30:0]        face_area,
    input  logic [16:0]        interp_factor,
    input  logic [30:0]        face_delta,
    input  logic [2:0]         bc_type,
    input  logic signed [31:0] boundary_value,
    output logic               done,
    output logic signed [31:0] face_flux,
    output logic signed [31:0] coef_pp,
    output logic signed [31:0] coef_pn,
    output logic signed [31:0] coef_np,
    output logic signed [31:0] coef_nn,
    output logic signed [31:0] source_add,
    output logic [15:0]        owner_out,
    output logic [15:0]        neighbour_out,
    output logic               boundary_out
);

    logic                     scheme_reg;
    logic signed [31:0]       vx_reg, vy_reg, vz_reg;
    logic                     front_valid;
    fvmcc_pkg::face_word_t    front_word, head_word;
    fvmcc_pkg::queue_status_t qstat;
    logic                     pop;
    logic [1:0]               ridx;

    // register file
    assign pready = 1'b1;
    assign ridx   = paddr[3:2];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scheme_reg <= 1'b0;
            vx_reg     <= '0;
            vy_reg     <= '0;
            vz_reg     <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (ridx)
                fvmcc_pkg::REG_SCHEME: scheme_reg <= pwdata[0];
                fvmcc_pkg::REG_VEL_X:  vx_reg     <= pwdata;
                fvmcc_pkg::REG_VEL_Y:  vy_reg     <= pwdata;
                fvmcc_pkg::REG_VEL_Z:  vz_reg     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            fvmcc_pkg::REG_SCHEME: prdata = {31'b0, scheme_reg};
            fvmcc_pkg::REG_VEL_X:  prdata = vx_reg;
            fvmcc_pkg::REG_VEL_Y:  prdata = vy_reg;
            fvmcc_pkg::REG_VEL_Z:  prdata = vz_reg;
            default:               prdata = '0;
        endcase
    end

    // back end never stalls, so the queue pops its head every cycle it is not empty
    assign busy = qstat.almost_full;
    assign pop  = !qstat.empty;

    fvmcc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(start && !busy),
        .scheme(scheme_reg), .vel_x(vx_reg), .vel_y(vy_reg), .vel_z(vz_reg),
        .owner_index(owner_index), .neighbour_index(neighbour_index),
        .is_boundary(is_boundary), .normal_x(normal_x), .normal_y(normal_y),
        .normal_z(normal_z), .face_area(face_area), .interp_factor(interp_factor),
        .face_delta(face_delta), .bc_type(bc_type), .boundary_value(boundary_value),
        .out_valid(front_valid), .out_word(front_word)
    );

    fvmcc_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(front_valid), .push_word(front_word),
        .pop(pop), .head_word(head_word), .status(qstat)
    );

    fvmcc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(pop), .in_word(head_word),
        .done(done), .face_flux(face_flux), .coef_pp(coef_pp), .coef_pn(coef_pn),
        .coef_np(coef_np), .coef_nn(coef_nn), .source_add(source_add),
        .owner_out(owner_out), .neighbour_out(neighbour_out),
        .boundary_out(boundary_out)
    );

endmodule
